// File: hw/rtl/swd_pkg.sv
// swd_pkg: shared types and constants for the stall window detector.
// No dependencies; imported by every RTL module and the testbench.
package swd_pkg;

   localparam int SWD_WINDOW    = 64;
   localparam int SWD_DATA_W    = 32;
   localparam int SWD_THRESH_W  = 31;
   localparam int SWD_CSR_IDX_W = 1;

   // CSR register indexes
   localparam logic [SWD_CSR_IDX_W-1:0] CSR_FREQ_THRESHOLD = 1'b0;
   localparam logic [SWD_CSR_IDX_W-1:0] CSR_POS_ACCURACY   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_HOLD
   } state_type;

   // Controls from sequencer to datapath
   typedef struct packed {
      logic load;    // shift a new item into the head of the chain
      logic rotate;  // circulate the chain by one cell
      logic first;   // first rotate cycle: tail is the oldest entry
      logic eval;    // compute spread and flag
      logic emit;    // move flag into the result register
      logic full;    // window has filled
   } ctrl_type;

endpackage

// File: hw/rtl/swd_cell.sv
// swd_cell: one window cell, holds a position and a frequency sample.
// Hands its contents to the next cell whenever the chain shifts. Uses swd_pkg.
module swd_cell
   import swd_pkg::*;
(
   input  logic                         clock,
   input  logic                         shift_en,
   input  logic signed [SWD_DATA_W-1:0] pos_in,
   input  logic signed [SWD_DATA_W-1:0] freq_in,
   output logic signed [SWD_DATA_W-1:0] pos_out,
   output logic signed [SWD_DATA_W-1:0] freq_out
);

   logic signed [SWD_DATA_W-1:0] pos_ff;
   logic signed [SWD_DATA_W-1:0] freq_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pos_ff  <= pos_in;
         freq_ff <= freq_in;
      end
   end

   assign pos_out  = pos_ff;
   assign freq_out = freq_ff;

endmodule

// File: hw/rtl/swd_ctrl.sv
// swd_ctrl: sequencer for one item - load, rotate scan, evaluate, hand off.
// Also keeps the saturating fill count. Uses swd_pkg.
module swd_ctrl
   import swd_pkg::*;
#(
   parameter int WINDOW = SWD_WINDOW
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     out_free,
   output ctrl_type ctrl
);

   localparam int CNT_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              accept;
   logic              scan_last;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign scan_last = (scan_cnt_ff == CNT_W'(WINDOW - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      ctrl.load   = accept;
      ctrl.rotate = (state_ff == ST_SCAN);
      ctrl.first  = (state_ff == ST_SCAN) && (scan_cnt_ff == '0);
      ctrl.eval   = (state_ff == ST_EVAL);
      ctrl.emit   = (state_ff == ST_HOLD) && out_free;
      ctrl.full   = (fill_ff == FILL_W'(WINDOW));
   end

   always_comb begin
      scan_cnt_in = '0;
      if (state_ff == ST_SCAN && !scan_last) scan_cnt_in = scan_cnt_ff + 1'b1;
      fill_in = fill_ff;
      if (accept && !ctrl.full) fill_in = fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_cnt_ff <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

// File: hw/rtl/stall_window_detector.sv
// stall_window_detector: top level, sliding-window motor stall detector.
// Depends on swd_pkg, swd_cell (window chain) and swd_ctrl (sequencer).
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  req     | req_valid/req_stall, position,frequency| in
//  rsp     | rsp_valid/rsp_stall, cannot_drive      | out
//  csr     | csr_wr_en, csr_index, csr_wdata        | in, write only
//
// Steps per item: shift the item in on accept, circulate the chain past the tail
//   min/max tracker, compare, then hand the result off.
// Reset: synchronous, clears sequencer, fill count, CSRs and rsp_valid; the chain is
//   not cleared, the flag is forced 0 until the window fills.
// Stalls: rsp_stall only delays the hand-off; a new item may be taken while the
//   previous result still waits in rsp.
module stall_window_detector
   import swd_pkg::*;
#(
   parameter int WINDOW = SWD_WINDOW
)
(
   input  logic                         clock,
   input  logic                         reset,
   // input items
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SWD_DATA_W-1:0] req_position,
   input  logic signed [SWD_DATA_W-1:0] req_frequency,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_cannot_drive,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [SWD_CSR_IDX_W-1:0]     csr_index,
   input  logic [SWD_DATA_W-1:0]        csr_wdata
);

   ctrl_type ctrl;
   logic     out_free;

   // ---------------- configuration registers ----------------
   logic [SWD_THRESH_W-1:0] freq_threshold_ff;
   logic [SWD_DATA_W-1:0]   pos_accuracy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_threshold_ff <= '0;
         pos_accuracy_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FREQ_THRESHOLD: freq_threshold_ff <= csr_wdata[SWD_THRESH_W-1:0];
            CSR_POS_ACCURACY:   pos_accuracy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   swd_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // ---------------- cell chain ----------------
   // Cell 0 is the newest item, cell WINDOW-1 the oldest. On load the chain
   // shifts and the oldest drops out; during the scan the tail feeds back to
   // the head, so after WINDOW rotations every cell is back in place.
   logic signed [SWD_DATA_W-1:0] pos_q  [WINDOW];
   logic signed [SWD_DATA_W-1:0] freq_q [WINDOW];
   logic signed [SWD_DATA_W-1:0] head_pos, head_freq;
   logic signed [SWD_DATA_W-1:0] tail_pos, tail_freq;
   logic                         shift_en;

   assign tail_pos  = pos_q[WINDOW-1];
   assign tail_freq = freq_q[WINDOW-1];
   assign head_pos  = ctrl.load ? req_position  : tail_pos;
   assign head_freq = ctrl.load ? req_frequency : tail_freq;
   assign shift_en  = ctrl.load || ctrl.rotate;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         swd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .pos_in   (head_pos),
            .freq_in  (head_freq),
            .pos_out  (pos_q[i]),
            .freq_out (freq_q[i])
         );
      end else begin : g_body
         swd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .pos_in   (pos_q[i-1]),
            .freq_in  (freq_q[i-1]),
            .pos_out  (pos_q[i]),
            .freq_out (freq_q[i])
         );
      end
   end

   // ---------------- tail tracker ----------------
   // On the first scan cycle the tail holds the oldest frequency; its
   // magnitude is taken then. Position min/max run over every scan cycle.
   logic signed [SWD_DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                         freq_ok_ff, freq_ok_in;
   logic [SWD_DATA_W-1:0]        freq_mag;
   logic [SWD_DATA_W:0]          spread;
   logic                         flag_ff, flag_in;

   // most negative input wraps to 2^31, which is right as unsigned
   assign freq_mag = tail_freq[SWD_DATA_W-1] ? (~tail_freq + 1'b1) : tail_freq;

   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      freq_ok_in = freq_ok_ff;
      if (ctrl.first) begin
         lo_in      = tail_pos;
         hi_in      = tail_pos;
         freq_ok_in = (freq_mag > {1'b0, freq_threshold_ff});
      end else if (ctrl.rotate) begin
         if (tail_pos < lo_ff) lo_in = tail_pos;
         if (tail_pos > hi_ff) hi_in = tail_pos;
      end
   end

   // hi >= lo, so the 33-bit difference is non-negative and fits 32 bits
   assign spread = {hi_ff[SWD_DATA_W-1], hi_ff} - {lo_ff[SWD_DATA_W-1], lo_ff};

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.eval) begin
         flag_in = ctrl.full && freq_ok_ff && (spread[SWD_DATA_W-1:0] <= pos_accuracy_ff);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      freq_ok_ff <= freq_ok_in;
      flag_ff    <= flag_in;
   end

   // ---------------- result register ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_cannot_drive_ff, rsp_cannot_drive_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_cannot_drive_in = rsp_cannot_drive_ff;
      if (ctrl.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_cannot_drive_in = flag_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cannot_drive_ff <= rsp_cannot_drive_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cannot_drive = rsp_cannot_drive_ff;

`ifndef SYNTHESIS
   // a result is only written into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result emitted over a pending item");

   // a new item never arrives in the middle of a scan
   a_load_rotate: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.load && ctrl.rotate))
      else $error("load during rotate");

   // after an accept the input side is held off while the chain circulates
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && ctrl.rotate && ctrl.first))
      else $error("scan did not start after accept");

   // a stall flag only comes out of a full window
   a_flag_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cannot_drive && $rose(rsp_valid)) |-> ctrl.full)
      else $error("flag set before window filled");
`endif

endmodule

// File: sim/stall_window_detector_test.sv
`timescale 1ns / 1ps
// stall_window_detector_test: self-checking testbench for the stall window detector.
// Depends on swd_pkg and the stall_window_detector RTL; needs no other files.
module stall_window_detector_test;
   import swd_pkg::*;

   localparam int WINDOW          = SWD_WINDOW;
   localparam int NUM_PHASES      = 10;
   localparam int PHASE_ITEMS     = 120;
   // Long receiver hold-off: long enough that the block parks one result, takes
   // one more item and then has to stall its input.
   localparam int PRESSURE_CYCLES = 500;
   // Slowest run is roughly 1250 items, each with the longest gap and stall, plus
   // two hold-offs; this is several times that.
   localparam int CYCLE_LIMIT     = 800000;

   typedef enum int {SEG_HOLD, SEG_NOISE, SEG_EXTREME} seg_kind_type;

   // Scoreboard: keeps its own copy of both delay lines and the two limits,
   // and queues the flag that each accepted item should produce.
   class stall_flag_board_type;
      logic signed [SWD_DATA_W-1:0] pos_hist [WINDOW];
      logic signed [SWD_DATA_W-1:0] freq_hist [WINDOW];
      int      fill;
      longint  thresh;
      longint  accuracy;
      bit      expected_flags [$];
      int      errors;

      function new();
         fill     = 0;
         thresh   = 0;
         accuracy = 0;
         errors   = 0;
      endfunction

      function void write_reg(logic [SWD_CSR_IDX_W-1:0] idx, logic [SWD_DATA_W-1:0] val);
         if (idx == CSR_FREQ_THRESHOLD) begin
            thresh = val[SWD_THRESH_W-1:0];
         end else if (idx == CSR_POS_ACCURACY) begin
            accuracy = val;
         end
      endfunction

      function int waiting();
         return expected_flags.size();
      endfunction

      function void note_sample(logic signed [SWD_DATA_W-1:0] pos,
                                logic signed [SWD_DATA_W-1:0] freq);
         longint oldest;
         longint lo;
         longint hi;
         bit     flag;
         int     i;
         // entry 0 newest, entry WINDOW-1 oldest
         for (i = WINDOW - 1; i > 0; i--) begin
            pos_hist[i]  = pos_hist[i-1];
            freq_hist[i] = freq_hist[i-1];
         end
         pos_hist[0]  = pos;
         freq_hist[0] = freq;
         if (fill < WINDOW) fill++;
         flag = 1'b0;
         if (fill == WINDOW) begin
            oldest = freq_hist[WINDOW-1];
            if (oldest < 0) oldest = -oldest;
            if (oldest > thresh) begin
               lo = pos_hist[0];
               hi = pos_hist[0];
               for (i = 1; i < WINDOW; i++) begin
                  if (pos_hist[i] < lo) lo = pos_hist[i];
                  if (pos_hist[i] > hi) hi = pos_hist[i];
               end
               flag = ((hi - lo) <= accuracy);
            end
         end
         expected_flags.push_back(flag);
      endfunction

      function void check_flag(logic got);
         bit want;
         if (expected_flags.size() == 0) begin
            $display("%0t: cannot_drive result with no item pending: expected none, got %b",
                     $time, got);
            errors++;
         end else begin
            want = expected_flags.pop_front();
            if (got !== want) begin
               $display("%0t: cannot_drive mismatch: expected %b, got %b", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [SWD_DATA_W-1:0] req_position;
   logic signed [SWD_DATA_W-1:0] req_frequency;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_cannot_drive;
   logic                         csr_wr_en;
   logic [SWD_CSR_IDX_W-1:0]     csr_index;
   logic [SWD_DATA_W-1:0]        csr_wdata;

   stall_flag_board_type board;
   int              cycle_count  = 0;
   int              results_seen = 0;
   bit              no_idle      = 1'b0;   // segment runs back to back
   longint unsigned thresh_now   = 0;      // limits in force, for shaping stimulus
   longint unsigned acc_now      = 0;

   stall_window_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_position     (req_position),
      .req_frequency    (req_frequency),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cannot_drive (rsp_cannot_drive),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL stall_window_detector");
         $finish;
      end
   end

   // Both handshakes are sampled at the edge, before this edge's drives land.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_sample(req_position, req_frequency);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_flag(rsp_cannot_drive);
         results_seen <= results_seen + 1;
      end
   end

   function automatic longint unsigned rand64();
      return {$urandom, $urandom};
   endfunction

   // Result side: runs of ready and stalled cycles, mostly short, some long,
   // plus a long hold-off at a couple of points in the run.
   initial begin : receiver
      int pick;
      int run_len;
      int pressure_mark;
      bit stall_val;
      rsp_stall     <= 1'b0;
      pressure_mark = 150;
      wait (reset === 1'b0);
      forever begin
         pick = $urandom_range(0, 99);
         if (results_seen >= pressure_mark) begin
            pressure_mark = pressure_mark + 600;
            stall_val     = 1'b1;
            run_len       = PRESSURE_CYCLES;
         end else if (pick < 70) begin
            stall_val = 1'b0;
            run_len   = $urandom_range(1, 20);
         end else if (pick < 95) begin
            stall_val = 1'b1;
            run_len   = $urandom_range(1, 4);
         end else begin
            stall_val = 1'b1;
            run_len   = $urandom_range(10, 40);
         end
         rsp_stall <= stall_val;
         repeat (run_len) @(posedge clock);
      end
   end

   // Offer one item and hold it until accepted. Valid stays high on return;
   // the next call or the caller lowers it, so each edge sees one update.
   task automatic send_sample(logic signed [SWD_DATA_W-1:0] pos,
                              logic signed [SWD_DATA_W-1:0] freq);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 60) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(5, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_position  <= pos;
      req_frequency <= freq;
      do @(posedge clock); while (req_stall);
   endtask

   // Both registers, back to back, only while the block is idle.
   task automatic set_limits(logic [SWD_DATA_W-1:0] thr_w, logic [SWD_DATA_W-1:0] acc_w);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FREQ_THRESHOLD;
      csr_wdata <= thr_w;
      board.write_reg(CSR_FREQ_THRESHOLD, thr_w);
      @(posedge clock);
      csr_index <= CSR_POS_ACCURACY;
      csr_wdata <= acc_w;
      board.write_reg(CSR_POS_ACCURACY, acc_w);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      thresh_now = thr_w[SWD_THRESH_W-1:0];   // top bit is dropped by the block
      acc_now    = acc_w;
   endtask

   // A run of items of one kind:
   //   hold    - positions inside a band whose width sits at, just above or
   //             well inside the accuracy; frequency mostly at or just above the threshold
   //   noise   - every bit random
   //   extreme - positions at both ends of the signed range (full-scale
   //             spread), frequencies at the most negative / most positive code
   task automatic run_segment(seg_kind_type kind, int len);
      longint unsigned span;
      longint unsigned base;
      longint unsigned off;
      longint unsigned mag;
      logic signed [SWD_DATA_W-1:0] pos;
      logic signed [SWD_DATA_W-1:0] freq;
      int k;
      case ($urandom_range(0, 3))
         0: span = acc_now;
         1: span = (acc_now == 64'hFFFF_FFFF) ? acc_now : acc_now + 1;
         2: span = acc_now / 2;
         default: span = $urandom_range(0, 16);
      endcase
      // band start in offset binary, chosen so the band never wraps
      base = rand64() % (64'h1_0000_0000 - span);
      for (k = 0; k < len; k++) begin
         case (kind)
            SEG_HOLD: begin
               case ($urandom_range(0, 3))
                  0: off = 0;
                  1: off = span;
                  default: off = rand64() % (span + 1);
               endcase
               pos = 32'(base + off) ^ 32'h8000_0000;
               case ($urandom_range(0, 5))
                  0, 1, 2: mag = thresh_now + 1 + $urandom_range(0, 1000);
                  3: mag = thresh_now;                  // equal is not enough
                  4: mag = $urandom_range(0, 3);
                  default: mag = rand64() % 64'h8000_0001;
               endcase
               if (mag >= 64'h8000_0000) freq = 32'h8000_0000;
               else if ($urandom_range(0, 1) == 1) freq = 32'(0 - mag);
               else freq = 32'(mag);
            end
            SEG_NOISE: begin
               pos  = $urandom;
               freq = $urandom;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: pos = 32'h8000_0000;
                  1: pos = 32'h7FFF_FFFF;
                  default: pos = $urandom;
               endcase
               case ($urandom_range(0, 2))
                  0: freq = 32'h8000_0000;   // magnitude 2^31 beats any threshold
                  1: freq = 32'h7FFF_FFFF;
                  default: freq = $urandom;
               endcase
            end
         endcase
         send_sample(pos, freq);
      end
   endtask

   initial begin : stimulus
      logic [SWD_DATA_W-1:0] corner [6];
      logic [SWD_DATA_W-1:0] thr_w;
      logic [SWD_DATA_W-1:0] acc_w;
      seg_kind_type          kind;
      int                    phase;
      int                    left;
      int                    len;
      int                    pick;
      int                    i;
      req_valid     <= 1'b0;
      req_position  <= '0;
      req_frequency <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_FREQ_THRESHOLD;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      board = new();
      corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and alternating patterns while the window
      // fills (flag must stay low), under the reset limits.
      for (i = 0; i < 6; i++) begin
         send_sample(corner[i], corner[5-i]);
         send_sample(corner[(i+2) % 6], corner[i]);
      end

      // Phases: the first three pin the limit extremes, the rest are random.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (board.waiting() != 0);
         repeat (4) @(posedge clock);
         case (phase)
            0: begin
               thr_w = 32'hFFFF_FFFF;   // top bit must be masked off
               acc_w = 32'hFFFF_FFFF;
            end
            1: begin
               thr_w = 32'h0000_0000;
               acc_w = 32'h0000_0000;
            end
            2: begin
               thr_w = 32'h7FFF_FFFE;
               acc_w = 32'hFFFF_FFFE;   // full-scale spread just fails
            end
            default: begin
               thr_w = $urandom;
               case ($urandom_range(0, 3))
                  0: thr_w[SWD_THRESH_W-1:0] = SWD_THRESH_W'($urandom_range(0, 1000));
                  1: thr_w[SWD_THRESH_W-1:0] = thr_w[SWD_THRESH_W-1:0] >> 12;
                  default: ;
               endcase
               case ($urandom_range(0, 3))
                  0: acc_w = $urandom_range(0, 64);
                  1: acc_w = $urandom >> 12;
                  2: acc_w = $urandom;
                  default: acc_w = '0;
               endcase
            end
         endcase
         set_limits(thr_w, acc_w);

         left = PHASE_ITEMS;
         while (left > 0) begin
            len = $urandom_range(40, 160);
            if (len > left) len = left;
            pick = $urandom_range(0, 9);
            if (phase < 3 && left == PHASE_ITEMS) kind = SEG_EXTREME;
            else if (pick < 6) kind = SEG_HOLD;
            else if (pick < 8) kind = SEG_NOISE;
            else kind = SEG_EXTREME;
            no_idle = ($urandom_range(0, 3) == 0);
            run_segment(kind, len);
            left = left - len;
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (board.waiting() != 0);
      repeat (WINDOW + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS stall_window_detector");
      end else begin
         $display("FAIL stall_window_detector");
      end
      $finish;
   end

endmodule

// File: stall_window_detector.f
hw/rtl/swd_pkg.sv
hw/rtl/swd_cell.sv
hw/rtl/swd_ctrl.sv
hw/rtl/stall_window_detector.sv
sim/stall_window_detector_test.sv
